// ----- hw/rtl/cls_pkg.sv -----
// Shared types and constants of the compacting list store.
`default_nettype none
package cls_pkg;

  localparam int DEPTH      = 64;
  localparam int VALUE_BITS = 32;
  localparam int POS_W      = 6;
  localparam int READ_W     = 32;
  localparam int COUNT_W    = 7;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [1:0] {
    MODE_APPEND = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_READ   = 2'd2,
    MODE_WRITE  = 2'd3
  } cls_mode_t;

  typedef struct packed {
    cls_mode_t          mode;
    logic [POS_W-1:0]   position;
    logic [READ_W-1:0]  value;
  } cls_req_t;

  typedef struct packed {
    logic [READ_W-1:0]  read_value;
    logic               ok;
    logic [COUNT_W-1:0] count;
  } cls_rsp_t;

  typedef struct packed {
    logic                  app;
    logic                  rm;
    logic                  wr;
    logic [CMP_W-1:0]      pos;
    logic [CMP_W-1:0]      cnt;
    logic [VALUE_BITS-1:0] value;
  } cls_cell_ctl_t;

endpackage
`default_nettype wire

// ----- hw/rtl/cls_cell.sv -----
// One storage cell of the list: holds one entry and takes its right neighbor's entry on removal.
`default_nettype none
module cls_cell
  import cls_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic [CMP_W-1:0]      cell_idx,
  input  wire cls_cell_ctl_t         ctl,
  input  wire logic [VALUE_BITS-1:0] nbr_data,
  output logic      [VALUE_BITS-1:0] data,
  output logic      [VALUE_BITS-1:0] rd_data
);

  logic [VALUE_BITS-1:0] data_r;
  logic [VALUE_BITS-1:0] data_nxt;
  logic                  hit;

  assign hit = (ctl.pos == cell_idx);

  always_comb begin
    data_nxt = data_r;
    if (ctl.wr && hit) begin
      data_nxt = ctl.value;
    end else if (ctl.app && (ctl.cnt == cell_idx)) begin
      data_nxt = ctl.value;
    end else if (ctl.rm && (cell_idx >= ctl.pos) && ((cell_idx + 1'b1) < ctl.cnt)) begin
      data_nxt = nbr_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data    = data_r;
  assign rd_data = hit ? data_r : '0;

endmodule
`default_nettype wire

// ----- hw/rtl/compacting_list_store.sv -----
// Top level of the compacting list store: request decode, cell row and response register.
//
// A bounded ordered list of up to DEPTH values. Each request on the in_ channel
// carries a mode (append, remove at index, read at index, write at index), a
// position and a value. Each request yields exactly one response on the out_
// channel with the value read, an ok flag and the entry count afterwards.
// A request is taken when in_valid is high and in_stall is low; a response is
// taken when out_valid is high and out_stall is low.
// Each request is handled in full as it is taken: the row of cells shifts all later
// entries down at once on removal, and reads come from an OR bus over the cells.
// The response is registered and appears in the cycle after the request is taken,
// and a new request is taken every cycle while the response register drains.
// When the receiver stalls, the response is held and in_stall rises until it
// is taken. Reset empties the list (count zero) and drops any pending response;
// stored entries are not cleared and are read only after being written.
`default_nettype none
module compacting_list_store
  import cls_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire cls_req_t in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output cls_rsp_t      out_data
);

  logic [CNT_W-1:0]      count_r;
  logic [CNT_W-1:0]      count_nxt;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  cls_rsp_t              out_data_r;
  cls_rsp_t              out_data_nxt;
  logic                  in_acc;
  logic                  in_range;
  logic                  full;
  logic [CMP_W-1:0]      pos_ext;
  logic [CMP_W-1:0]      cnt_ext;
  logic                  ok;
  logic [VALUE_BITS-1:0] rd_or;
  cls_cell_ctl_t         ctl;

  logic [VALUE_BITS-1:0] cell_data [DEPTH];
  logic [VALUE_BITS-1:0] cell_rd   [DEPTH];
  logic [VALUE_BITS-1:0] cell_nbr  [DEPTH];

  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;
  assign pos_ext  = CMP_W'(in_data.position);
  assign cnt_ext  = CMP_W'(count_r);
  assign in_range = pos_ext < cnt_ext;
  assign full     = (count_r == CNT_W'(DEPTH));

  always_comb begin
    ok      = 1'b0;
    ctl.app = 1'b0;
    ctl.rm  = 1'b0;
    ctl.wr  = 1'b0;
    unique case (in_data.mode)
      MODE_APPEND: ok = !full;
      MODE_REMOVE: ok = in_range;
      MODE_READ:   ok = in_range;
      MODE_WRITE:  ok = in_range;
      default:     ok = 1'b0;
    endcase
    ctl.app   = in_acc && ok && (in_data.mode == MODE_APPEND);
    ctl.rm    = in_acc && ok && (in_data.mode == MODE_REMOVE);
    ctl.wr    = in_acc && ok && (in_data.mode == MODE_WRITE);
    ctl.pos   = pos_ext;
    ctl.cnt   = cnt_ext;
    ctl.value = VALUE_BITS'(in_data.value);
  end

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      if (gi == DEPTH - 1) begin : g_last
        assign cell_nbr[gi] = '0;
      end else begin : g_mid
        assign cell_nbr[gi] = cell_data[gi+1];
      end
      cls_cell u_cell (
        .clk      (clk),
        .cell_idx (CMP_W'(gi)),
        .ctl      (ctl),
        .nbr_data (cell_nbr[gi]),
        .data     (cell_data[gi]),
        .rd_data  (cell_rd[gi])
      );
    end
  endgenerate

  always_comb begin
    rd_or = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_or = rd_or | cell_rd[i];
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (ctl.app) begin
      count_nxt = count_r + 1'b1;
    end else if (ctl.rm) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_comb begin
    out_data_nxt            = out_data_r;
    out_valid_nxt           = out_valid_r && out_stall;
    if (in_acc) begin
      out_valid_nxt           = 1'b1;
      out_data_nxt.ok         = ok;
      out_data_nxt.count      = COUNT_W'(count_nxt);
      out_data_nxt.read_value = (ok && (in_data.mode == MODE_READ)) ? READ_W'(rd_or) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count exceeds capacity");

  a_count_only_on_request: assert property (@(posedge clk) disable iff (!rst_n)
    !in_acc |=> $stable(count_r))
    else $error("entry count changed without a request");

  a_response_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("request taken without a response");

  a_fail_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.ok) |-> (out_data_r.read_value == '0))
    else $error("failed request returned nonzero data");

endmodule
`default_nettype wire
